/* rtl/core/asc_pkg.sv */
// ----------------------------------------------------------------------------
// asc_pkg
// Shared widths, CORDIC constants and elaboration helpers for the angular
// separation check.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

  localparam int STEPS         = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ERRW          = 25;   // width of the summed error radii
  localparam int XW            = 34;   // rotation datapath, signed Q30
  localparam int VW            = 36;   // vectoring datapath, signed Q30
  localparam int ZW            = 42;   // angles, signed degrees Q32

  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  // degrees per radian with 40 fraction bits
  localparam longint DPR = 64'sd62997375797123;

  // Restoring long division of two non-negative values, for elaboration only
  function automatic longint div_pos(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32 degrees, from the arctangent power series
  function automatic longint atan_q32(input int i);
    longint p;
    longint sum;
    longint term;
    if (i == 0) begin
      return 64'sd45 <<< 32;
    end
    p   = DPR >>> i;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        term = div_pos(p, longint'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else      sum = sum + term;
        p = p >>> (2 * i);
      end
    end
    return (sum + 64'sd128) >>> 8;
  endfunction

  // Smallest s with (360 << fb) << s covering any signed 26-bit angle
  function automatic int mod_shift(input int fb);
    int s;
    s = 0;
    for (int k = 0; k < 40; k++) begin
      if ((64'd360 << (fb + s)) < (64'd1 << 25)) s++;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/asc_rot_cell.sv */
// ----------------------------------------------------------------------------
// asc_rot_cell
// One rotation CORDIC iteration, applied to three angles side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_rot_cell #(
  parameter int     SHIFT = 0,
  parameter longint ATAN  = 0,
  parameter int     SW    = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            vld_in,
  input  logic signed [asc_pkg::XW-1:0]   x_in [3],
  input  logic signed [asc_pkg::XW-1:0]   y_in [3],
  input  logic signed [asc_pkg::ZW-1:0]   z_in [3],
  input  logic [SW-1:0]                   side_in,
  output logic                            vld_out,
  output logic signed [asc_pkg::XW-1:0]   x_out [3],
  output logic signed [asc_pkg::XW-1:0]   y_out [3],
  output logic signed [asc_pkg::ZW-1:0]   z_out [3],
  output logic [SW-1:0]                   side_out
);

  localparam logic signed [asc_pkg::ZW-1:0] ATAN_Z = asc_pkg::ZW'(ATAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      for (int l = 0; l < 3; l++) begin
        // rotate towards zero residual angle
        if (!z_in[l][asc_pkg::ZW-1]) begin
          x_out[l] <= x_in[l] - (y_in[l] >>> SHIFT);
          y_out[l] <= y_in[l] + (x_in[l] >>> SHIFT);
          z_out[l] <= z_in[l] - ATAN_Z;
        end else begin
          x_out[l] <= x_in[l] + (y_in[l] >>> SHIFT);
          y_out[l] <= y_in[l] - (x_in[l] >>> SHIFT);
          z_out[l] <= z_in[l] + ATAN_Z;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/asc_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// asc_sqrt_cell
// One step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_sqrt_cell #(
  parameter int BITP = 62,
  parameter int SW   = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [63:0]   v_in,
  input  logic [63:0]   r_in,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [63:0]   v_out,
  output logic [63:0]   r_out,
  output logic [SW-1:0] side_out
);

  localparam logic [63:0] BIT = 64'd1 << BITP;

  logic [63:0] trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/asc_vec_cell.sv */
// ----------------------------------------------------------------------------
// asc_vec_cell
// One vectoring CORDIC iteration for the final arctangent.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_vec_cell #(
  parameter int     SHIFT = 0,
  parameter longint ATAN  = 0,
  parameter int     SW    = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic signed [asc_pkg::VW-1:0] x_in,
  input  logic signed [asc_pkg::VW-1:0] y_in,
  input  logic signed [asc_pkg::ZW-1:0] z_in,
  input  logic [SW-1:0]                 side_in,
  output logic                          vld_out,
  output logic signed [asc_pkg::VW-1:0] x_out,
  output logic signed [asc_pkg::VW-1:0] y_out,
  output logic signed [asc_pkg::ZW-1:0] z_out,
  output logic [SW-1:0]                 side_out
);

  localparam logic signed [asc_pkg::ZW-1:0] ATAN_Z = asc_pkg::ZW'(ATAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      // drive y towards zero, accumulate the angle turned
      if (!y_in[asc_pkg::VW-1]) begin
        x_out <= x_in + (y_in >>> SHIFT);
        y_out <= y_in - (x_in >>> SHIFT);
        z_out <= z_in + ATAN_Z;
      end else begin
        x_out <= x_in - (y_in >>> SHIFT);
        y_out <= y_in + (x_in >>> SHIFT);
        z_out <= z_in - ATAN_Z;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/angular_separation_check.sv */
// ----------------------------------------------------------------------------
// angular_separation_check
// Great-circle separation of two sky positions (Vincenty form) and a flag
// for separation beyond the summed error radii.
// ----------------------------------------------------------------------------
// Fully pipelined: one position pair is taken every clock cycle while
// in_stall is low. The pipe is built from chains of cells: the modulo-360
// reduction with S extra steps (S = 1 at 16 fraction bits), 32 rotation
// CORDIC cells for the three sine/cosine pairs, three multiplier stages,
// 32 square-root cells and 32 vectoring CORDIC cells. The whole pipe holds
// while the output register holds a result that is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module angular_separation_check #(
  parameter int FRAC_BITS = asc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [24:0] ra_a,
  input  logic [23:0] dec_a,
  input  logic [23:0] err_a,
  input  logic [24:0] ra_b,
  input  logic [23:0] dec_b,
  input  logic [23:0] err_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] sep_deg,
  output logic        apart
);

  localparam int     STEPS = asc_pkg::STEPS;
  localparam int     XW    = asc_pkg::XW;
  localparam int     VW    = asc_pkg::VW;
  localparam int     ZW    = asc_pkg::ZW;
  localparam int     ERRW  = asc_pkg::ERRW;
  localparam int     SH    = asc_pkg::mod_shift(FRAC_BITS);
  localparam longint MODV  = 64'sd360 <<< FRAC_BITS;
  localparam longint OFFS  = MODV <<< SH;
  localparam int     UW    = $clog2(MODV <<< (SH + 1));
  localparam int     AW    = UW + 1;
  localparam int     RSW   = 3 + ERRW;
  localparam int     QSW   = XW + ERRW;
  localparam int     TSW   = 2 + ERRW;

  localparam logic signed [AW-1:0] M_S = AW'(MODV);
  localparam logic signed [AW-1:0] H_S = AW'(MODV / 2);
  localparam logic signed [AW-1:0] Q_S = AW'(MODV / 4);
  localparam logic signed [ZW-1:0] Z180  = ZW'(64'sd180 <<< 32);
  localparam logic signed [ZW-1:0] HALFU = ZW'(64'sd1 <<< (31 - FRAC_BITS));
  localparam logic signed [ZW-1:0] SEPMX = ZW'(64'sd180 <<< FRAC_BITS);

  function automatic logic signed [XW-1:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return XW'(p >>> 30);
  endfunction

  logic en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Input stage and modulo-360 reduction
  // --------------------------------------------------------------------------
  logic signed [26:0] vin [3];
  logic [UW-1:0]      mu  [0:SH+1][3];
  logic               mv  [0:SH+1];
  logic [ERRW-1:0]    me  [0:SH+1];

  always_comb begin
    vin[0] = 27'(signed'(dec_a));
    vin[1] = 27'(signed'(dec_b));
    vin[2] = $signed({2'b00, ra_a}) - $signed({2'b00, ra_b});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv[0] <= 1'b0;
    end else if (en) begin
      mv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      me[0] <= {1'b0, err_a} + {1'b0, err_b};
      for (int l = 0; l < 3; l++) begin
        // bias negative angles up by a whole number of turns
        mu[0][l] <= UW'(64'(vin[l]) + OFFS);
      end
    end
  end

  for (genvar j = 0; j <= SH; j++) begin : g_mod
    localparam logic [UW-1:0] D = UW'(MODV <<< (SH - j));

    always_ff @(posedge clk) begin
      if (rst) begin
        mv[j+1] <= 1'b0;
      end else if (en) begin
        mv[j+1] <= mv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        me[j+1] <= me[j];
        for (int l = 0; l < 3; l++) begin
          mu[j+1][l] <= (mu[j][l] >= D) ? mu[j][l] - D : mu[j][l];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Fold into -90..90 and scale to Q32 degrees
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] fa [3];
  logic signed [AW-1:0] fb [3];
  logic signed [AW-1:0] fc [3];
  logic                 ff [3];
  logic signed [ZW-1:0] pz [3];
  logic                 pf [3];
  logic                 pv;
  logic [ERRW-1:0]      pe;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fa[l] = $signed({1'b0, mu[SH+1][l]});
      fb[l] = (fa[l] > H_S) ? fa[l] - M_S : fa[l];
      if (fb[l] > Q_S) begin
        fc[l] = fb[l] - H_S;
        ff[l] = 1'b1;
      end else if (fb[l] < -Q_S) begin
        fc[l] = fb[l] + H_S;
        ff[l] = 1'b1;
      end else begin
        fc[l] = fb[l];
        ff[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= mv[SH+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe <= me[SH+1];
      for (int l = 0; l < 3; l++) begin
        pz[l] <= ZW'(fc[l]) <<< (32 - FRAC_BITS);
        pf[l] <= ff[l];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sine and cosine: rotation CORDIC chain
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] rx [0:STEPS][3];
  logic signed [XW-1:0] ry [0:STEPS][3];
  logic signed [ZW-1:0] rz [0:STEPS][3];
  logic                 rv [0:STEPS];
  logic [RSW-1:0]       rs [0:STEPS];

  for (genvar l = 0; l < 3; l++) begin : g_rot_in
    assign rx[0][l] = asc_pkg::GAIN_Q30;
    assign ry[0][l] = '0;
    assign rz[0][l] = pz[l];
  end
  assign rv[0] = pv;
  assign rs[0] = {pf[2], pf[1], pf[0], pe};

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    asc_rot_cell #(
      .SHIFT (i),
      .ATAN  (asc_pkg::atan_q32(i)),
      .SW    (RSW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (rv[i]),
      .x_in     (rx[i]),
      .y_in     (ry[i]),
      .z_in     (rz[i]),
      .side_in  (rs[i]),
      .vld_out  (rv[i+1]),
      .x_out    (rx[i+1]),
      .y_out    (ry[i+1]),
      .z_out    (rz[i+1]),
      .side_out (rs[i+1])
    );
  end

  logic signed [31:0] sn [3];
  logic signed [31:0] cs [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (rs[STEPS][ERRW+l]) begin
        sn[l] = 32'(-ry[STEPS][l]);
        cs[l] = 32'(-rx[STEPS][l]);
      end else begin
        sn[l] = 32'(ry[STEPS][l]);
        cs[l] = 32'(rx[STEPS][l]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Products: A, B, C and A*A + B*B
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] p1a;
  logic signed [XW-1:0] p1t1;
  logic signed [XW-1:0] p1t2;
  logic signed [XW-1:0] p1t3;
  logic signed [XW-1:0] p1t4;
  logic signed [31:0]   p1cd;
  logic                 p1v;
  logic [ERRW-1:0]      p1e;

  logic signed [XW-1:0] p2a;
  logic signed [XW-1:0] p2b;
  logic signed [XW-1:0] p2c;
  logic                 p2v;
  logic [ERRW-1:0]      p2e;

  logic signed [63:0]   sqa;
  logic signed [63:0]   sqb;
  logic [63:0]          p3q;
  logic signed [XW-1:0] p3c;
  logic                 p3v;
  logic [ERRW-1:0]      p3e;

  assign sqa = 32'(p2a) * 32'(p2a);
  assign sqb = 32'(p2b) * 32'(p2b);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
    end else if (en) begin
      p1v <= rv[STEPS];
      p2v <= p1v;
      p3v <= p2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1a  <= mul30(cs[1], sn[2]);
      p1t1 <= mul30(cs[0], sn[1]);
      p1t2 <= mul30(sn[0], cs[1]);
      p1t3 <= mul30(sn[0], sn[1]);
      p1t4 <= mul30(cs[0], cs[1]);
      p1cd <= cs[2];
      p1e  <= rs[STEPS][ERRW-1:0];

      p2a <= p1a;
      p2b <= p1t1 - mul30(32'(p1t2), p1cd);
      p2c <= p1t3 + mul30(32'(p1t4), p1cd);
      p2e <= p1e;

      p3q <= $unsigned(sqa) + $unsigned(sqb);
      p3c <= p2c;
      p3e <= p2e;
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain
  // --------------------------------------------------------------------------
  logic [63:0]    qv [0:STEPS];
  logic [63:0]    qr [0:STEPS];
  logic           qd [0:STEPS];
  logic [QSW-1:0] qs [0:STEPS];

  assign qv[0] = p3q;
  assign qr[0] = '0;
  assign qd[0] = p3v;
  assign qs[0] = {p3c, p3e};

  for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
    asc_sqrt_cell #(
      .BITP (62 - 2 * i),
      .SW   (QSW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (qd[i]),
      .v_in     (qv[i]),
      .r_in     (qr[i]),
      .side_in  (qs[i]),
      .vld_out  (qd[i+1]),
      .v_out    (qv[i+1]),
      .r_out    (qr[i+1]),
      .side_out (qs[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // atan2(root, C): vectoring CORDIC chain
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] cval;
  logic signed [VW-1:0] tx [0:STEPS];
  logic signed [VW-1:0] ty [0:STEPS];
  logic signed [ZW-1:0] tz [0:STEPS];
  logic                 tv [0:STEPS];
  logic [TSW-1:0]       ts [0:STEPS];
  logic signed [VW-1:0] vx0;
  logic signed [VW-1:0] vy0;
  logic                 vback;
  logic                 vzero;
  logic                 vv0;
  logic [ERRW-1:0]      ve0;

  assign cval = qs[STEPS][QSW-1:ERRW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv0 <= 1'b0;
    end else if (en) begin
      vv0 <= qd[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // mirror a negative C into the right half-plane, undo at the end
      vx0   <= cval[XW-1] ? -VW'(cval) : VW'(cval);
      vy0   <= $signed({1'b0, qr[STEPS][VW-2:0]});
      vback <= cval[XW-1];
      vzero <= (qr[STEPS] == '0) && (cval == '0);
      ve0   <= qs[STEPS][ERRW-1:0];
    end
  end

  assign tx[0] = vx0;
  assign ty[0] = vy0;
  assign tz[0] = '0;
  assign tv[0] = vv0;
  assign ts[0] = {vzero, vback, ve0};

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    asc_vec_cell #(
      .SHIFT (i),
      .ATAN  (asc_pkg::atan_q32(i)),
      .SW    (TSW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (tv[i]),
      .x_in     (tx[i]),
      .y_in     (ty[i]),
      .z_in     (tz[i]),
      .side_in  (ts[i]),
      .vld_out  (tv[i+1]),
      .x_out    (tx[i+1]),
      .y_out    (ty[i+1]),
      .z_out    (tz[i+1]),
      .side_out (ts[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Round, clamp, compare; output register
  // --------------------------------------------------------------------------
  logic signed [ZW-1:0] zfin;
  logic signed [ZW-1:0] zrnd;
  logic signed [ZW-1:0] sepv;

  always_comb begin
    if (ts[STEPS][TSW-1]) begin
      zfin = '0;
    end else if (ts[STEPS][TSW-2]) begin
      zfin = Z180 - tz[STEPS];
    end else begin
      zfin = tz[STEPS];
    end
    zrnd = (zfin + HALFU) >>> (32 - FRAC_BITS);
    if (zfin[ZW-1]) begin
      sepv = '0;
    end else if (zrnd > SEPMX) begin
      sepv = SEPMX;
    end else begin
      sepv = zrnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sep_deg <= sepv[23:0];
      apart   <= sepv > $signed({{(ZW - ERRW){1'b0}}, ts[STEPS][ERRW-1:0]});
    end
  end

endmodule

`default_nettype wire

/* bench/tb_angular_separation_check.sv */
// ----------------------------------------------------------------------------
// tb_angular_separation_check
// Checks the pipelined great-circle separation block against a bit-exact
// predictor: directed sky corners, flag boundaries, then random pairs with
// random idle bursts on both sides and a final stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_angular_separation_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB         = asc_pkg::FRAC_BITS_DEF;
  localparam int NSTEP      = 32;
  localparam int LATENCY    = 105;
  localparam int CYCLE_MAX  = 400000;
  localparam longint GAIN   = 64'sd652032874;

  typedef struct packed {
    logic [23:0] sep;
    logic        apart;
  } sep_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [24:0] ra_a = '0;
  logic [23:0] dec_a = '0;
  logic [23:0] err_a = '0;
  logic [24:0] ra_b = '0;
  logic [23:0] dec_b = '0;
  logic [23:0] err_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] sep_deg;
  logic        apart;

  longint      arctan_rom [NSTEP];
  sep_result_t sep_queue [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          requests_sent = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  always #1 clk = ~clk;

  angular_separation_check #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .ra_a(ra_a), .dec_a(dec_a), .err_a(err_a),
    .ra_b(ra_b), .dec_b(dec_b), .err_b(err_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .sep_deg(sep_deg), .apart(apart)
  );

  function automatic longint deg_q32(input longint d);
    return d <<< 32;
  endfunction

  function automatic longint series_arctan(input longint n);
    longint p, sum, k, term;
    p = (64'sd1 <<< 56) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      sum = k[0] ? sum - term : sum + term;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic void fill_arctan_rom();
    longint qpi, num, dpr, r, p, sum, k, term;
    qpi = 4 * series_arctan(5) - series_arctan(239);
    num = 64'sd45 * (64'sd1 <<< 56);
    dpr = num / qpi;
    r = num % qpi;
    for (int b = 0; b < 40; b++) begin
      r = r <<< 1;
      dpr = dpr <<< 1;
      if (r >= qpi) begin
        r = r - qpi;
        dpr = dpr | 1;
      end
    end
    arctan_rom[0] = deg_q32(45);
    for (int i = 1; i < NSTEP; i++) begin
      p = dpr >>> i;
      sum = 0;
      k = 0;
      while (p != 0) begin
        term = p / (2 * k + 1);
        sum = k[0] ? sum - term : sum + term;
        p = (2 * i < 63) ? (p >>> (2 * i)) : 0;
        k++;
      end
      arctan_rom[i] = (sum + 128) >>> 8;
    end
  endfunction

  function automatic void rotate_sin_cos(input longint ang, output longint s,
                                         output longint c);
    longint m, x, y, z, dx, dy;
    bit flip;
    m = deg_q32(360);
    x = GAIN;
    y = 0;
    flip = 1'b0;
    ang = ang % m;
    if (ang < 0) ang += m;
    if (ang > m / 2) ang -= m;
    if (ang > deg_q32(90)) begin
      ang -= deg_q32(180);
      flip = 1'b1;
    end else if (ang < -deg_q32(90)) begin
      ang += deg_q32(180);
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_rom[i];
      end else begin
        x += dx; y -= dy; z += arctan_rom[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint int_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, dx, dy;
    bit back;
    if (y == 0 && x == 0) return 0;
    back = 1'b0;
    z = 0;
    if (x < 0) begin
      x = -x;
      back = 1'b1;
    end
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_rom[i];
      end else begin
        x -= dx; y += dy; z -= arctan_rom[i];
      end
    end
    return back ? deg_q32(180) - z : z;
  endfunction

  function automatic sep_result_t predict_separation(
      input logic [24:0] ra1, input logic [23:0] de1, input logic [23:0] er1,
      input logic [24:0] ra2, input logic [23:0] de2, input logic [23:0] er2);
    longint unit, s1, c1, s2, c2, sd, cd, a, b, c, z, sep;
    longint unsigned sq;
    sep_result_t r;
    unit = 64'sd1 <<< (32 - FB);
    rotate_sin_cos(longint'($signed(de1)) * unit, s1, c1);
    rotate_sin_cos(longint'($signed(de2)) * unit, s2, c2);
    rotate_sin_cos((longint'(ra1) - longint'(ra2)) * unit, sd, cd);
    a = qmul(c2, sd);
    b = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
    c = qmul(s1, s2) + qmul(qmul(c1, c2), cd);
    sq = longint'(a * a) + longint'(b * b);
    z = vector_angle(int_root(sq), c);
    sep = (z + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
    if (z < 0) sep = 0;
    if (sep > (64'sd180 <<< FB)) sep = 64'sd180 <<< FB;
    r.sep = sep[23:0];
    r.apart = (sep > longint'(er1) + longint'(er2));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycles, what);
    mismatches++;
  endtask

  // Send one request; the payload holds until it is taken.
  task automatic send_request(input logic [24:0] r1, input logic [23:0] d1,
                              input logic [23:0] e1, input logic [24:0] r2,
                              input logic [23:0] d2, input logic [23:0] e2);
    sep_result_t exp_r;
    int gap;
    exp_r = predict_separation(r1, d1, e1, r2, d2, e2);
    ra_a <= r1; dec_a <= d1; err_a <= e1;
    ra_b <= r2; dec_b <= d2; err_b <= e2;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sep_queue.push_back(exp_r);
    requests_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] deg(input int d);
    return 24'(d <<< FB);
  endfunction

  function automatic logic [23:0] rand_dec();
    return 24'(int'($urandom_range(0, 11796480)) - 5898240);
  endfunction

  task automatic test_sky_corners();
    logic [24:0] ra_top;
    ra_top = 25'd23592959;
    send_request(0, 0, 0, 0, 0, 0);                            // same point
    send_request(25'(deg(10)), deg(20), 0, 25'(deg(10)), deg(20), 24'd1);
    send_request(0, deg(90), 0, 0, -deg(90), 0);               // pole to pole
    send_request(0, 0, 0, 25'(deg(180)), 0, 0);                // antipodal
    send_request(ra_top, -deg(90), 24'd11796480, 0, deg(90), 24'd11796480);
    send_request(ra_top, 0, 0, 0, 0, 0);                       // wrap at 360
    send_request(25'h1FFFFFF, 0, 0, 0, 0, 0);                  // ra beyond range
    send_request(25'h1FFFFFF, 24'h7FFFFF, 24'hFFFFFF, 25'h0, 24'h800000,
                 24'hFFFFFF);                                  // dec beyond range
    send_request(25'(deg(359)), deg(45), 0, 25'(deg(1)), deg(45), 0);
    send_request(25'(deg(90)), deg(89), 0, 25'(deg(270)), deg(89), 0);
    send_request(25'd1, 0, 0, 0, 0, 0);                        // one lsb apart
    send_request(0, deg(90), 0, 25'(deg(123)), deg(90), 0);    // same pole
    send_request(25'(deg(180)), deg(-30), 0, 0, deg(30), 0);
  endtask

  // Separation against error sums equal to it and just below it; the equal sum is also split across both sides.
  task automatic test_flag_boundary();
    sep_result_t p;
    logic [24:0] r1, r2;
    logic [23:0] d1, d2;
    for (int n = 0; n < 4; n++) begin
      r1 = 25'($urandom_range(0, 23592959));
      r2 = 25'($urandom_range(0, 23592959));
      d1 = rand_dec();
      d2 = rand_dec();
      p = predict_separation(r1, d1, 0, r2, d2, 0);
      send_request(r1, d1, p.sep, r2, d2, 0);
      send_request(r1, d1, p.sep - 24'd1, r2, d2, 0);
      if (p.sep > 1) send_request(r1, d1, 24'd1, r2, d2, p.sep - 24'd1);
    end
  endtask

  task automatic test_random_sky(input int count);
    logic [24:0] r1;
    logic [23:0] d1;
    for (int n = 0; n < count; n++) begin
      r1 = 25'($urandom_range(0, 23592959));
      d1 = rand_dec();
      if ($urandom_range(0, 4) == 0)       // close pairs
        send_request(r1, d1, 24'($urandom_range(0, 65536)),
                     r1 + 25'($urandom_range(0, 131072)),
                     d1 + 24'($urandom_range(0, 131072)),
                     24'($urandom_range(0, 65536)));
      else
        send_request(r1, d1, 24'($urandom_range(0, 11796480)),
                     25'($urandom_range(0, 23592959)), rand_dec(),
                     24'($urandom_range(0, 11796480)));
    end
  endtask

  task automatic test_raw_fields(input int count);
    for (int n = 0; n < count; n++)
      send_request(25'($urandom), 24'($urandom), 24'($urandom),
                   25'($urandom), 24'($urandom), 24'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(1, 15);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sep_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (sep_queue.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        e = sep_queue.pop_front();
        if (sep_deg !== e.sep)
          report_mismatch($sformatf("sep_deg %0d, want %0d", sep_deg, e.sep));
        if (apart !== e.apart)
          report_mismatch($sformatf("apart %0b, want %0b", apart, e.apart));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    fill_arctan_rom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sky_corners();
    test_flag_boundary();
    test_random_sky(900);
    test_raw_fields(150);
    idle_on = 1'b0;
    test_random_sky(200);
    in_valid <= 1'b0;
    while (sep_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sep_queue.size() != 0) report_mismatch("results left outstanding");
    $display("Sent %0d position pairs (corners, flag edges, random, raw fields),",
             requests_sent);
    $display("checked %0d results with idle bursts on both sides.", results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
